>>> rtl/core/ll2s_pkg.sv
// ----------------------------------------------------------------------------
// ll2s_pkg
// Shared constants, types and elaboration-time tables for the lat/lon to
// sphere coordinate unit.
// ----------------------------------------------------------------------------
package ll2s_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int XY_W   = 33;
  localparam int Z_W    = 34;
  localparam int ANG_W  = 18;
  localparam int MAG_W  = 14;
  localparam int QUO_W  = 32;
  localparam int REM_W  = 16;
  localparam int OUT_W  = 16;

  localparam longint FULL_TURN    = 46080;
  localparam longint HALF_TURN    = 23040;
  localparam longint QUARTER_TURN = 11520;
  localparam longint PI_Q30       = 64'd3373259426;
  localparam longint CORDIC_X0    = 652032874;
  localparam longint FLAT_RECIP   = 11930465;
  localparam int     FLAT_SHIFT   = 30;
  localparam longint FLAT_LIMIT   = 23040;

  typedef logic [QUO_W-1:0] quo_tab_t [0:127];
  typedef logic [REM_W-1:0] rem_tab_t [0:127];
  typedef logic [31:0]      atan_tab_t [0:ATAN_ENTRIES-1];

  localparam atan_tab_t ATAN_Q30 = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  function automatic quo_tab_t build_hi_quo();
    quo_tab_t t;
    longint   n;
    for (int h = 0; h < 128; h++) begin
      n    = longint'(h) * 256 * PI_Q30;
      t[h] = QUO_W'(n / (2 * HALF_TURN));
    end
    return t;
  endfunction

  function automatic rem_tab_t build_hi_rem();
    rem_tab_t t;
    longint   n;
    for (int h = 0; h < 128; h++) begin
      n    = longint'(h) * 256 * PI_Q30;
      t[h] = REM_W'(n % (2 * HALF_TURN));
    end
    return t;
  endfunction

  function automatic quo_tab_t build_lo_quo();
    quo_tab_t t;
    longint   n;
    for (int l = 0; l < 128; l++) begin
      n    = longint'(l) * 2 * PI_Q30 + HALF_TURN;
      t[l] = QUO_W'(n / (2 * HALF_TURN));
    end
    return t;
  endfunction

  function automatic rem_tab_t build_lo_rem();
    rem_tab_t t;
    longint   n;
    for (int l = 0; l < 128; l++) begin
      n    = longint'(l) * 2 * PI_Q30 + HALF_TURN;
      t[l] = REM_W'(n % (2 * HALF_TURN));
    end
    return t;
  endfunction

  localparam quo_tab_t HI_QUO = build_hi_quo();
  localparam rem_tab_t HI_REM = build_hi_rem();
  localparam quo_tab_t LO_QUO = build_lo_quo();
  localparam rem_tab_t LO_REM = build_lo_rem();

endpackage

>>> rtl/core/ll2s_angle_prep.sv
// ----------------------------------------------------------------------------
// ll2s_angle_prep
// Folds an angle into [-90, 90] degrees and converts it to Q2.30 radians.
// ----------------------------------------------------------------------------
module ll2s_angle_prep (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ll2s_pkg::ANG_W-1:0] angle,
  output logic signed [ll2s_pkg::Z_W-1:0]   z_out,
  output logic                              neg_cos
);

  localparam int RW = ll2s_pkg::ANG_W + 1;

  logic signed [RW-1:0]             v;
  logic signed [RW-1:0]             a;
  logic signed [RW-1:0]             r;
  logic                             fold;
  logic                             p1_sign_r;
  logic                             p1_neg_r;
  logic [ll2s_pkg::MAG_W-1:0]       p1_mag_r;
  logic                             p2_sign_r;
  logic                             p2_neg_r;
  logic [ll2s_pkg::QUO_W-1:0]       p2_quo_r;
  logic [ll2s_pkg::REM_W:0]         p2_rem_r;
  logic [ll2s_pkg::QUO_W-1:0]       mag;
  logic signed [ll2s_pkg::Z_W-1:0]  z_r;
  logic                             p3_neg_r;

  always_comb begin
    v = RW'(angle);
    if (v < -RW'(ll2s_pkg::FULL_TURN)) begin
      a = v + RW'(2 * ll2s_pkg::FULL_TURN);
    end else if (v < 0) begin
      a = v + RW'(ll2s_pkg::FULL_TURN);
    end else if (v >= RW'(ll2s_pkg::FULL_TURN)) begin
      a = v - RW'(ll2s_pkg::FULL_TURN);
    end else begin
      a = v;
    end
    fold = 1'b0;
    if (a > RW'(3 * ll2s_pkg::QUARTER_TURN)) begin
      r = a - RW'(ll2s_pkg::FULL_TURN);
    end else if (a > RW'(ll2s_pkg::QUARTER_TURN)) begin
      r    = RW'(ll2s_pkg::HALF_TURN) - a;
      fold = 1'b1;
    end else begin
      r = a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sign_r <= r[RW-1];
      p1_neg_r  <= fold;
      p1_mag_r  <= r[RW-1] ? ll2s_pkg::MAG_W'(-r) : ll2s_pkg::MAG_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sign_r <= p1_sign_r;
      p2_neg_r  <= p1_neg_r;
      p2_quo_r  <= ll2s_pkg::HI_QUO[p1_mag_r[13:7]] + ll2s_pkg::LO_QUO[p1_mag_r[6:0]];
      p2_rem_r  <= {1'b0, ll2s_pkg::HI_REM[p1_mag_r[13:7]]}
                 + {1'b0, ll2s_pkg::LO_REM[p1_mag_r[6:0]]};
    end
  end

  assign mag = p2_quo_r
             + ll2s_pkg::QUO_W'(p2_rem_r >= (ll2s_pkg::REM_W+1)'(2 * ll2s_pkg::HALF_TURN));

  always_ff @(posedge clk) begin
    if (en) begin
      p3_neg_r <= p2_neg_r;
      z_r      <= p2_sign_r ? -ll2s_pkg::Z_W'(mag) : ll2s_pkg::Z_W'(mag);
    end
  end

  assign z_out   = z_r;
  assign neg_cos = p3_neg_r;

endmodule

>>> rtl/core/ll2s_cordic_cell.sv
// ----------------------------------------------------------------------------
// ll2s_cordic_cell
// One CORDIC rotation step with its output registers.
// ----------------------------------------------------------------------------
module ll2s_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ll2s_pkg::XY_W-1:0]  x_in,
  input  logic signed [ll2s_pkg::XY_W-1:0]  y_in,
  input  logic signed [ll2s_pkg::Z_W-1:0]   z_in,
  input  logic                              side_in,
  output logic signed [ll2s_pkg::XY_W-1:0]  x_out,
  output logic signed [ll2s_pkg::XY_W-1:0]  y_out,
  output logic signed [ll2s_pkg::Z_W-1:0]   z_out,
  output logic                              side_out
);

  localparam logic signed [ll2s_pkg::Z_W-1:0] ATAN =
    ll2s_pkg::Z_W'(ll2s_pkg::ATAN_Q30[STAGE_IDX]);

  logic signed [ll2s_pkg::XY_W-1:0] dx;
  logic signed [ll2s_pkg::XY_W-1:0] dy;
  logic signed [ll2s_pkg::XY_W-1:0] x_r;
  logic signed [ll2s_pkg::XY_W-1:0] y_r;
  logic signed [ll2s_pkg::Z_W-1:0]  z_r;
  logic                             side_r;

  assign dx = y_in >>> STAGE_IDX;
  assign dy = x_in >>> STAGE_IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      if (!z_in[ll2s_pkg::Z_W-1]) begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - ATAN;
      end else begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + ATAN;
      end
    end
  end

  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign side_out = side_r;

endmodule

>>> rtl/core/ll2s_flat_scale.sv
// ----------------------------------------------------------------------------
// ll2s_flat_scale
// Scales an angle by 1/180 into Q1.15, rounded and saturated; two stages.
// ----------------------------------------------------------------------------
module ll2s_flat_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ll2s_pkg::ANG_W-1:0] angle,
  output logic signed [ll2s_pkg::OUT_W-1:0] flat
);

  logic [ll2s_pkg::ANG_W-1:0] m;
  logic [21:0]                n;
  logic [45:0]                prod;
  logic                       sign_r;
  logic                       big_r;
  logic [ll2s_pkg::OUT_W-1:0] q_r;
  logic signed [ll2s_pkg::OUT_W-1:0] flat_r;

  assign m    = angle[ll2s_pkg::ANG_W-1] ? ll2s_pkg::ANG_W'(-angle) : ll2s_pkg::ANG_W'(angle);
  assign n    = {m[14:0], 7'd0} + 22'd45;
  assign prod = 46'(n) * 46'(ll2s_pkg::FLAT_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      sign_r <= angle[ll2s_pkg::ANG_W-1];
      big_r  <= m >= ll2s_pkg::ANG_W'(ll2s_pkg::FLAT_LIMIT);
      q_r    <= prod[ll2s_pkg::FLAT_SHIFT +: ll2s_pkg::OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (big_r) begin
        flat_r <= sign_r ? 16'sh8000 : 16'sh7fff;
      end else begin
        flat_r <= sign_r ? -$signed(q_r) : $signed(q_r);
      end
    end
  end

  assign flat = flat_r;

endmodule

>>> rtl/core/latlon_to_sphere_xyz_unit.sv
// ----------------------------------------------------------------------------
// latlon_to_sphere_xyz_unit
// Lat/lon grid point to unit-sphere xyz and flat map coordinates.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry lat_angle and lon_angle in 1/128
// degree units; a transfer takes place when valid is high and stall is low.
// Result channel: out_valid / out_stall carry sphere_x, sphere_y, sphere_z,
// flat_x and flat_y in Q1.15, one result per input transfer.
// From input transfer to out_valid an item passes the input register, three
// angle preparation stages, one stage per CORDIC cell, the product stage and
// the output register. Throughput is one item per cycle unless out_stall
// holds the pipeline, set by the CORDIC cells taking an angle when enabled.
// Reset clears all valid flags; out_valid is low after reset.
// While out_stall holds a waiting result, the whole pipeline holds and
// in_stall is raised; gaps between items travel as empty slots.
// ----------------------------------------------------------------------------
module latlon_to_sphere_xyz_unit #(
  parameter int CORDIC_STAGES = ll2s_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] in_lat_angle,
  input  logic signed [16:0] in_lon_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sphere_x,
  output logic signed [15:0] out_sphere_y,
  output logic signed [15:0] out_sphere_z,
  output logic signed [15:0] out_flat_x,
  output logic signed [15:0] out_flat_y
);

  localparam int NS  = (CORDIC_STAGES < ll2s_pkg::ATAN_ENTRIES) ? CORDIC_STAGES
                                                               : ll2s_pkg::ATAN_ENTRIES;
  localparam int LAT = NS + 6;
  localparam int XW  = ll2s_pkg::XY_W;
  localparam int ZW  = ll2s_pkg::Z_W;
  localparam int AW  = ll2s_pkg::ANG_W;

  logic                  en;
  logic [LAT-1:0]        vld_r;
  logic [LAT-1:0]        vld_nxt;
  logic signed [AW-1:0]  lat_r;
  logic signed [AW-1:0]  lon_r;
  logic signed [AW-1:0]  fx_in;
  logic signed [ZW-1:0]  z_lat;
  logic signed [ZW-1:0]  z_lon;
  logic                  neg_lat;
  logic                  neg_lon;
  logic signed [XW-1:0]  lat_x [0:NS];
  logic signed [XW-1:0]  lat_y [0:NS];
  logic signed [ZW-1:0]  lat_z [0:NS];
  logic                  lat_s [0:NS];
  logic signed [XW-1:0]  lon_x [0:NS];
  logic signed [XW-1:0]  lon_y [0:NS];
  logic signed [ZW-1:0]  lon_z [0:NS];
  logic                  lon_s [0:NS];
  logic signed [15:0]    flat_x;
  logic signed [15:0]    flat_y;
  logic signed [15:0]    fx_d_r [0:NS+1];
  logic signed [15:0]    fy_d_r [0:NS+1];
  logic signed [XW-1:0]  cos_lat;
  logic signed [XW-1:0]  cos_lon;
  logic signed [63:0]    px_r;
  logic signed [63:0]    pz_r;
  logic signed [15:0]    sy_r;
  logic signed [XW:0]    y_rnd;
  logic signed [18:0]    y_sh;
  logic signed [63:0]    px_rnd;
  logic signed [63:0]    pz_rnd;
  logic signed [18:0]    px_sh;
  logic signed [18:0]    pz_sh;
  logic signed [15:0]    ox_r;
  logic signed [15:0]    oy_r;
  logic signed [15:0]    oz_r;
  logic signed [15:0]    ofx_r;
  logic signed [15:0]    ofy_r;

  function automatic logic signed [15:0] sat_sym(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sd32767;
    end else if (v < -19'sd32767) begin
      return -16'sd32767;
    end
    return v[15:0];
  endfunction

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_r <= AW'(in_lat_angle);
      lon_r <= AW'(in_lon_angle);
    end
  end

  assign fx_in = (lon_r > AW'(ll2s_pkg::HALF_TURN)) ? lon_r - AW'(ll2s_pkg::FULL_TURN) : lon_r;

  ll2s_angle_prep u_prep_lat (.clk(clk), .en(en), .angle(lat_r), .z_out(z_lat), .neg_cos(neg_lat));
  ll2s_angle_prep u_prep_lon (.clk(clk), .en(en), .angle(lon_r), .z_out(z_lon), .neg_cos(neg_lon));

  ll2s_flat_scale u_flat_x (.clk(clk), .en(en), .angle(fx_in), .flat(flat_x));
  ll2s_flat_scale u_flat_y (.clk(clk), .en(en), .angle(lat_r), .flat(flat_y));

  assign lat_x[0] = XW'(ll2s_pkg::CORDIC_X0);
  assign lat_y[0] = '0;
  assign lat_z[0] = z_lat;
  assign lat_s[0] = neg_lat;
  assign lon_x[0] = XW'(ll2s_pkg::CORDIC_X0);
  assign lon_y[0] = '0;
  assign lon_z[0] = z_lon;
  assign lon_s[0] = neg_lon;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    ll2s_cordic_cell #(.STAGE_IDX(i)) u_lat_cell (
      .clk(clk), .en(en),
      .x_in(lat_x[i]), .y_in(lat_y[i]), .z_in(lat_z[i]), .side_in(lat_s[i]),
      .x_out(lat_x[i+1]), .y_out(lat_y[i+1]), .z_out(lat_z[i+1]), .side_out(lat_s[i+1])
    );
    ll2s_cordic_cell #(.STAGE_IDX(i)) u_lon_cell (
      .clk(clk), .en(en),
      .x_in(lon_x[i]), .y_in(lon_y[i]), .z_in(lon_z[i]), .side_in(lon_s[i]),
      .x_out(lon_x[i+1]), .y_out(lon_y[i+1]), .z_out(lon_z[i+1]), .side_out(lon_s[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_d_r[0] <= flat_x;
      fy_d_r[0] <= flat_y;
      for (int k = 1; k <= NS + 1; k++) begin
        fx_d_r[k] <= fx_d_r[k-1];
        fy_d_r[k] <= fy_d_r[k-1];
      end
    end
  end

  assign cos_lat = lat_s[NS] ? -lat_x[NS] : lat_x[NS];
  assign cos_lon = lon_s[NS] ? -lon_x[NS] : lon_x[NS];
  assign y_rnd   = (XW+1)'(lat_y[NS]) + (XW+1)'(1 << 14);
  assign y_sh    = 19'(y_rnd >>> 15);

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 64'($signed(cos_lat[31:0])) * 64'($signed(lon_y[NS][31:0]));
      pz_r <= 64'($signed(cos_lat[31:0])) * 64'($signed(cos_lon[31:0]));
      sy_r <= sat_sym(y_sh);
    end
  end

  assign px_rnd = px_r + (64'sd1 <<< 44);
  assign pz_rnd = pz_r + (64'sd1 <<< 44);
  assign px_sh  = 19'(px_rnd >>> 45);
  assign pz_sh  = 19'(pz_rnd >>> 45);

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r  <= sat_sym(px_sh);
      oz_r  <= sat_sym(pz_sh);
      oy_r  <= sy_r;
      ofx_r <= fx_d_r[NS+1];
      ofy_r <= fy_d_r[NS+1];
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_sphere_x = ox_r;
  assign out_sphere_y = oy_r;
  assign out_sphere_z = oz_r;
  assign out_flat_x   = ofx_r;
  assign out_flat_y   = ofy_r;

endmodule
